// ===== rtl/mlet_pkg.sv =====
// ----------------------------------------------------------------------------
// mlet_pkg
// Shared widths and the node entry type of the min-of-lines envelope tree.
// ----------------------------------------------------------------------------
package mlet_pkg;

    localparam int unsigned DOMAIN     = 1024;
    localparam int unsigned NODE_DEPTH = 2 * DOMAIN;
    localparam int unsigned NODE_AW    = $clog2(NODE_DEPTH);
    localparam int unsigned XW         = 10;
    localparam int unsigned SLOPE_W    = 32;
    localparam int unsigned ICPT_W     = 64;
    localparam int unsigned IN_TDATA_W = 112;

    typedef struct packed {
        logic               valid;
        logic [SLOPE_W-1:0] slope;
        logic [ICPT_W-1:0]  icpt;
    } node_t;

    localparam int unsigned NODE_W = $bits(node_t);

endpackage

// ===== rtl/mlet_ram.sv =====
// ----------------------------------------------------------------------------
// mlet_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlet_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/mlet_eval.sv =====
// ----------------------------------------------------------------------------
// mlet_eval
// Shared line evaluator: slope*x + intercept, wrapping at 64 bits.
// Multiply stage then add stage; the product and intercept are registered, then the sum.
// ----------------------------------------------------------------------------
module mlet_eval (
    input  logic                                clk,
    input  logic signed [mlet_pkg::SLOPE_W-1:0] slope,
    input  logic        [mlet_pkg::ICPT_W-1:0]  intercept,
    input  logic        [mlet_pkg::XW-1:0]      x,
    output logic        [mlet_pkg::ICPT_W-1:0]  value
);

    localparam int unsigned PROD_W = mlet_pkg::SLOPE_W + mlet_pkg::XW + 1;

    logic signed [PROD_W-1:0]           prod;
    logic signed [PROD_W-1:0]           prod_reg;
    logic        [mlet_pkg::ICPT_W-1:0] icpt_reg;
    logic        [mlet_pkg::ICPT_W-1:0] value_reg;
    logic signed [mlet_pkg::XW:0]       x_s;
    logic        [mlet_pkg::ICPT_W-1:0] prod_ext;

    assign x_s      = $signed({1'b0, x});
    assign prod     = PROD_W'(slope) * PROD_W'(x_s);
    assign prod_ext = mlet_pkg::ICPT_W'(prod_reg);
    assign value    = value_reg;

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod;
        icpt_reg  <= intercept;
        value_reg <= prod_ext + icpt_reg;
    end

endmodule

// ===== rtl/min_line_envelope_tree.sv =====
// ----------------------------------------------------------------------------
// min_line_envelope_tree
// Li Chao tree over x = 0..domain_max holding lines y = slope*x + intercept.
// ----------------------------------------------------------------------------
// One word is processed at a time. After reset the node RAM is swept clear,
// all 2048 rows, while s_tready is low. An insert makes, at each level, up to
// three line evaluation pairs (midpoint, left end, right end), over at most
// 11 levels (the leaf level only compares at the midpoint); a query evaluates
// every stored line met on its path, then loads the output register. Both
// share the single multiply/add evaluator and the one-read node RAM.
module min_line_envelope_tree (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slope[31:0], intercept[95:32], x[105:96], zero pad
    input  logic [mlet_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // min_value[63:0]
    output logic [mlet_pkg::ICPT_W-1:0]         m_tdata,
    // empty_res[0], out_of_range[1]
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [mlet_pkg::XW-1:0]             cfg_wdata
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_MUL_T = 4'd4;
    localparam logic [3:0] S_ADD_T = 4'd5;
    localparam logic [3:0] S_MUL_K = 4'd6;
    localparam logic [3:0] S_ADD_K = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_QACC  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [1:0] PH_MID = 2'd0;
    localparam logic [1:0] PH_LO  = 2'd1;
    localparam logic [1:0] PH_HI  = 2'd2;

    localparam int unsigned AW = mlet_pkg::NODE_AW;
    localparam int unsigned XW = mlet_pkg::XW;
    localparam int unsigned KW = mlet_pkg::SLOPE_W;
    localparam int unsigned BW = mlet_pkg::ICPT_W;

    localparam logic [AW-1:0] ROOT     = AW'(1);
    localparam logic [AW-1:0] LAST_ROW = AW'(mlet_pkg::NODE_DEPTH - 1);

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [XW-1:0] domain_reg, domain_next;
    logic          is_query_reg, is_query_next;
    logic          oor_reg, oor_next;
    logic          found_reg, found_next;
    logic [1:0]    phase_reg, phase_next;
    logic [AW-1:0] node_reg, node_next;
    logic [XW-1:0] lo_reg, lo_next;
    logic [XW-1:0] hi_reg, hi_next;
    logic [XW-1:0] x_reg, x_next;
    logic [KW-1:0] k_slope_reg, k_slope_next;
    logic [BW-1:0] k_icpt_reg, k_icpt_next;
    logic [KW-1:0] t_slope_reg, t_slope_next;
    logic [BW-1:0] t_icpt_reg, t_icpt_next;
    logic [BW-1:0] tv_reg, tv_next;
    logic [BW-1:0] best_reg, best_next;
    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] out_value_reg, out_value_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_oor_reg, out_oor_next;

    mlet_pkg::node_t ram_wdata;
    mlet_pkg::node_t ram_rdata;
    logic [mlet_pkg::NODE_W-1:0] ram_rbits;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;

    logic [KW-1:0] ev_slope;
    logic [BW-1:0] ev_icpt;
    logic [XW-1:0] ev_x;
    logic [BW-1:0] ev_value;

    logic [XW:0]   mid_sum;
    logic [XW-1:0] mid;
    logic [AW:0]   child_l;
    logic [AW:0]   child_r;
    logic          gt;
    logic          lo_eq_hi;
    logic          in_accept;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[XW:1];
    assign child_l   = {node_reg, 1'b0};
    assign child_r   = {node_reg, 1'b1};
    assign lo_eq_hi  = (lo_reg == hi_reg);
    assign gt        = $signed(tv_reg) > $signed(ev_value);
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign ram_rdata = mlet_pkg::node_t'(ram_rbits);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_oor_reg, out_empty_reg};

    always_comb
    begin
        ev_slope = t_slope_reg;
        ev_icpt  = t_icpt_reg;
        if (state_reg == S_MUL_K)
        begin
            ev_slope = k_slope_reg;
            ev_icpt  = k_icpt_reg;
        end
        if (is_query_reg)
        begin
            ev_x = x_reg;
        end
        else
        begin
            case (phase_reg)
                PH_MID:  ev_x = mid;
                PH_LO:   ev_x = lo_reg;
                PH_HI:   ev_x = hi_reg;
                default: ev_x = mid;
            endcase
        end
    end

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = node_reg;
        ram_wdata.valid = 1'b1;
        ram_wdata.slope = k_slope_reg;
        ram_wdata.icpt  = k_icpt_reg;
        ram_re          = (state_reg == S_READ);
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_CHECK && !is_query_reg && !ram_rdata.valid)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_CMP && phase_reg == PH_MID && gt)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        domain_next    = domain_reg;
        is_query_next  = is_query_reg;
        oor_next       = oor_reg;
        found_next     = found_reg;
        phase_next     = phase_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        k_slope_next   = k_slope_reg;
        k_icpt_next    = k_icpt_reg;
        t_slope_next   = t_slope_reg;
        t_icpt_next    = t_icpt_reg;
        tv_next        = tv_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_empty_next = out_empty_reg;
        out_oor_next   = out_oor_reg;

        if (cfg_we)
        begin
            domain_next = cfg_wdata;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    is_query_next = s_tuser[0];
                    k_slope_next  = s_tdata[31:0];
                    k_icpt_next   = s_tdata[95:32];
                    x_next        = s_tdata[105:96];
                    node_next     = ROOT;
                    lo_next       = '0;
                    hi_next       = domain_reg;
                    phase_next    = PH_MID;
                    found_next    = 1'b0;
                    best_next     = '0;
                    oor_next      = 1'b0;
                    state_next    = S_READ;
                    if (s_tuser[0] && s_tdata[105:96] > domain_reg)
                    begin
                        oor_next   = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                t_slope_next = ram_rdata.slope;
                t_icpt_next  = ram_rdata.icpt;
                phase_next   = PH_MID;
                if (ram_rdata.valid)
                begin
                    state_next = S_MUL_T;
                end
                else if (!is_query_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (lo_eq_hi)
                begin
                    state_next = S_OUT;
                end
                else if (x_reg <= mid)
                begin
                    node_next  = child_l[AW-1:0];
                    hi_next    = mid;
                    state_next = child_l[AW] ? S_OUT : S_READ;
                end
                else
                begin
                    node_next  = child_r[AW-1:0];
                    lo_next    = mid + XW'(1);
                    state_next = child_r[AW] ? S_OUT : S_READ;
                end
            end
            S_MUL_T:
            begin
                state_next = S_ADD_T;
            end
            S_ADD_T:
            begin
                state_next = is_query_reg ? S_QACC : S_MUL_K;
            end
            S_MUL_K:
            begin
                tv_next    = ev_value;
                state_next = S_ADD_K;
            end
            S_ADD_K:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                case (phase_reg)
                    PH_MID:
                    begin
                        if (gt)
                        begin
                            k_slope_next = t_slope_reg;
                            k_icpt_next  = t_icpt_reg;
                            t_slope_next = k_slope_reg;
                            t_icpt_next  = k_icpt_reg;
                        end
                        phase_next = PH_LO;
                        state_next = lo_eq_hi ? S_IDLE : S_MUL_T;
                    end
                    PH_LO:
                    begin
                        if (gt)
                        begin
                            node_next  = child_l[AW-1:0];
                            hi_next    = mid;
                            state_next = child_l[AW] ? S_IDLE : S_READ;
                        end
                        else
                        begin
                            phase_next = PH_HI;
                            state_next = S_MUL_T;
                        end
                    end
                    default:
                    begin
                        if (gt)
                        begin
                            node_next  = child_r[AW-1:0];
                            lo_next    = mid + XW'(1);
                            state_next = child_r[AW] ? S_IDLE : S_READ;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_QACC:
            begin
                if (!found_reg || $signed(best_reg) > $signed(ev_value))
                begin
                    best_next = ev_value;
                end
                found_next = 1'b1;
                if (lo_eq_hi)
                begin
                    state_next = S_OUT;
                end
                else if (x_reg <= mid)
                begin
                    node_next  = child_l[AW-1:0];
                    hi_next    = mid;
                    state_next = child_l[AW] ? S_OUT : S_READ;
                end
                else
                begin
                    node_next  = child_r[AW-1:0];
                    lo_next    = mid + XW'(1);
                    state_next = child_r[AW] ? S_OUT : S_READ;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = found_reg ? best_reg : '0;
                    out_empty_next = !found_reg && !oor_reg;
                    out_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            domain_reg    <= XW'(1023);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            domain_reg    <= domain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_query_reg  <= is_query_next;
        oor_reg       <= oor_next;
        found_reg     <= found_next;
        phase_reg     <= phase_next;
        node_reg      <= node_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        x_reg         <= x_next;
        k_slope_reg   <= k_slope_next;
        k_icpt_reg    <= k_icpt_next;
        t_slope_reg   <= t_slope_next;
        t_icpt_reg    <= t_icpt_next;
        tv_reg        <= tv_next;
        best_reg      <= best_next;
        out_value_reg <= out_value_next;
        out_empty_reg <= out_empty_next;
        out_oor_reg   <= out_oor_next;
    end

    mlet_ram #(
        .WIDTH (mlet_pkg::NODE_W),
        .DEPTH (mlet_pkg::NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (node_reg),
        .rdata (ram_rbits)
    );

    mlet_eval u_eval (
        .clk       (clk),
        .slope     (ev_slope),
        .intercept (ev_icpt),
        .x         (ev_x),
        .value     (ev_value)
    );

endmodule

// ===== rtl/mlet_checker.sv =====
// ----------------------------------------------------------------------------
// mlet_checker
// Port-level checks of the envelope tree, bound to the top level.
// ----------------------------------------------------------------------------
module mlet_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mlet_pkg::ICPT_W-1:0]     m_tdata,
    input logic [1:0]                      m_tuser
);

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a word while busy");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("empty and out-of-range both set");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata == '0)
        else $error("flagged result carries a value");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind min_line_envelope_tree mlet_checker u_mlet_checker (.*);

// ===== tb/line_env_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// line_env_tb_pkg
// Operation codes shared by the envelope tree stimulus and its checker.
// ----------------------------------------------------------------------------
package line_env_tb_pkg;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

endpackage

// ===== tb/line_envelope_checker.sv =====
// ----------------------------------------------------------------------------
// line_envelope_checker
// Watches the input, output and register ports of the envelope tree. It keeps
// its own copy of the line tree and the domain register, works out the
// minimum for every accepted query word and compares each output word with
// the oldest outstanding answer.
// ----------------------------------------------------------------------------
module line_envelope_checker
    import mlet_pkg::*;
    import line_env_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [ICPT_W-1:0]     m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [XW-1:0]         cfg_wdata,
    output int                    mismatch_count,
    output int                    results_due
);

    typedef struct packed {
        logic [ICPT_W-1:0] min_value;
        logic              empty_res;
        logic              out_of_range;
    } query_result_t;

    localparam int unsigned MAX_REPORTS = 10;

    logic              node_used [NODE_DEPTH];
    logic [SLOPE_W-1:0] node_k   [NODE_DEPTH];
    logic [ICPT_W-1:0]  node_b   [NODE_DEPTH];
    logic [XW-1:0]      span_max;
    query_result_t      minima_due [$];

    // slope * x + intercept, wrapping at 64 bits
    function automatic logic [ICPT_W-1:0] line_value(input logic [SLOPE_W-1:0] k,
                                                     input logic [ICPT_W-1:0] b,
                                                     input int unsigned x);
        logic [ICPT_W-1:0] k_ext;
        logic [ICPT_W-1:0] x_ext;
        k_ext = {{(ICPT_W-SLOPE_W){k[SLOPE_W-1]}}, k};
        x_ext = {{(ICPT_W-XW){1'b0}}, XW'(x)};
        return k_ext * x_ext + b;
    endfunction

    function automatic logic above(input logic [ICPT_W-1:0] a, input logic [ICPT_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

    task automatic envelope_insert(input logic [SLOPE_W-1:0] k_in,
                                   input logic [ICPT_W-1:0] b_in);
        logic [SLOPE_W-1:0] k;
        logic [SLOPE_W-1:0] tk;
        logic [ICPT_W-1:0]  b;
        logic [ICPT_W-1:0]  tb;
        int unsigned        node;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        k = k_in;
        b = b_in;
        node = 1;
        lo = 0;
        hi = span_max;
        while (node < NODE_DEPTH)
        begin
            if (!node_used[node])
            begin
                node_used[node] = 1'b1;
                node_k[node] = k;
                node_b[node] = b;
                return;
            end
            mid = (lo + hi) >> 1;
            tk = node_k[node];
            tb = node_b[node];
            // keep the line lower at the midpoint, push the other one down
            if (above(line_value(tk, tb, mid), line_value(k, b, mid)))
            begin
                node_k[node] = k;
                node_b[node] = b;
                {k, tk} = {tk, k};
                {b, tb} = {tb, b};
            end
            if (lo == hi)
                return;
            if (above(line_value(tk, tb, lo), line_value(k, b, lo)))
            begin
                node = node << 1;
                hi = mid;
            end
            else if (above(line_value(tk, tb, hi), line_value(k, b, hi)))
            begin
                node = (node << 1) | 1;
                lo = mid + 1;
            end
            else
                return;
        end
    endtask

    function automatic query_result_t envelope_query(input logic [XW-1:0] x);
        query_result_t     r;
        logic [ICPT_W-1:0] v;
        int unsigned       node;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       mid;
        r = '0;
        hi = span_max;
        if (x > hi)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        r.empty_res = 1'b1;
        node = 1;
        lo = 0;
        while (node < NODE_DEPTH)
        begin
            if (node_used[node])
            begin
                v = line_value(node_k[node], node_b[node], x);
                if (r.empty_res || above(r.min_value, v))
                    r.min_value = v;
                r.empty_res = 1'b0;
            end
            if (lo == hi)
                break;
            mid = (lo + hi) >> 1;
            if (x <= mid)
            begin
                node = node << 1;
                hi = mid;
            end
            else
            begin
                node = (node << 1) | 1;
                lo = mid + 1;
            end
        end
        return r;
    endfunction

    task automatic note_miss(input string what, input query_result_t want,
                             input query_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: expected min=%h empty=%b oor=%b, got min=%h empty=%b oor=%b",
                     $time, what, want.min_value, want.empty_res, want.out_of_range,
                     got.min_value, got.empty_res, got.out_of_range);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        query_result_t want;
        query_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_DEPTH; i++)
                node_used[i] = 1'b0;
            span_max = XW'(DOMAIN - 1);
            minima_due.delete();
            mismatch_count = 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
                span_max = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                got.min_value = m_tdata;
                got.empty_res = m_tuser[0];
                got.out_of_range = m_tuser[1];
                if (minima_due.size() == 0)
                    note_miss("unexpected word", '0, got);
                else
                begin
                    want = minima_due.pop_front();
                    if (got != want)
                        note_miss("mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (op_t'(s_tuser[0]) == OP_QUERY)
                    minima_due.insert(minima_due.size(), envelope_query(s_tdata[105:96]));
                else
                    envelope_insert(s_tdata[31:0], s_tdata[95:32]);
            end
            results_due <= minima_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the min-of-lines envelope tree: directed extremes, then random
// insert and query words over a series of domain settings, with bursty input,
// a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import mlet_pkg::*;
    import line_env_tb_pkg::*;

    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 700;
    localparam int PHASE_WORDS   = 148;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [ICPT_W-1:0]     m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [XW-1:0]         cfg_wdata = '0;

    int          mismatch_count;
    int          results_due;
    int          quiet_cycles = 0;
    int          burst_left = 1;
    bit          hold_req = 1'b0;
    int unsigned domain_now = DOMAIN - 1;

    min_line_envelope_tree uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    line_envelope_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // output side: runs of mixed ready patterns, plus one long hold-off
    initial
    begin : sink
        int run;
        int mode;
        bit held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                @(posedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (run)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_word(input op_t op, input logic [SLOPE_W-1:0] k,
                             input logic [ICPT_W-1:0] b, input logic [XW-1:0] x);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(IN_TDATA_W-XW-ICPT_W-SLOPE_W){1'b0}}, x, b, k};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60)
                                               : $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic go_quiet;
        s_tvalid <= 1'b0;
    endtask

    task automatic drain;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // inserts leave no result, so allow the longest insert to finish as well
    task automatic set_domain(input int unsigned v);
        go_quiet();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= XW'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        domain_now = v;
    endtask

    task automatic random_word;
        op_t                op;
        logic [SLOPE_W-1:0] k;
        logic [ICPT_W-1:0]  b;
        logic [XW-1:0]      x;
        int                 pick;
        op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_QUERY;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            // lines that cross inside the domain, so they sink deep
            k = SLOPE_W'(int'($urandom_range(0, 4000)) - 2000);
            b = ICPT_W'(longint'($urandom_range(0, 2000000)) - 64'sd1000000);
        end
        else if (pick < 8)
        begin
            k = SLOPE_W'(int'($urandom_range(0, 2097152)) - 1048576);
            b = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom), 32'($urandom)};
        end
        else
        begin
            k = $urandom;
            b = {32'($urandom), 32'($urandom)};
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            x = '0;
        else if (pick == 1)
            x = XW'(domain_now);
        else if (pick == 2)
            x = XW'($urandom_range(0, DOMAIN - 1));
        else
            x = XW'($urandom_range(0, domain_now));
        send_word(op, k, b, x);
    endtask

    initial
    begin : stimulus
        int unsigned domains [9];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        set_domain(DOMAIN - 1);
        send_word(OP_QUERY, '0, '0, 10'd0);
        send_word(OP_QUERY, '1, '1, 10'd1023);
        send_word(OP_INSERT, 32'd0, 64'd0, 10'd0);
        send_word(OP_INSERT, 32'h7fff_ffff, 64'h8000_0000_0000_0000, 10'd1023);
        send_word(OP_INSERT, 32'h8000_0000, 64'h7fff_ffff_ffff_ffff, 10'd512);
        send_word(OP_INSERT, 32'hffff_ffff, 64'd1000, 10'd3);
        send_word(OP_INSERT, 32'd1, -64'sd600, 10'd7);
        send_word(OP_INSERT, 32'd3, 64'h3f3f_3f3f_3f3f_3f3f, 10'd0);
        send_word(OP_INSERT, -32'sd5, 64'd3000, 10'd0);
        send_word(OP_QUERY, 32'hffff_ffff, '1, 10'd0);
        send_word(OP_QUERY, '0, '0, 10'd1023);
        send_word(OP_QUERY, '0, '0, 10'd511);
        send_word(OP_QUERY, '0, '0, 10'd512);
        send_word(OP_QUERY, '0, '0, 10'd300);

        // single point domain: only the root is used
        set_domain(0);
        send_word(OP_QUERY, '0, '0, 10'd0);
        send_word(OP_INSERT, 32'd2, -64'sd7, 10'd0);
        send_word(OP_QUERY, '0, '0, 10'd0);
        send_word(OP_QUERY, '0, '0, 10'd1);
        send_word(OP_QUERY, '0, '0, 10'd1023);

        set_domain(1);
        send_word(OP_INSERT, -32'sd4, 64'd1, 10'd0);
        send_word(OP_QUERY, '0, '0, 10'd0);
        send_word(OP_QUERY, '0, '0, 10'd1);
        send_word(OP_QUERY, '0, '0, 10'd2);

        domains = '{DOMAIN - 1, 5, DOMAIN - 1, 64, 1, 700, DOMAIN - 1,
                    $urandom_range(2, DOMAIN - 2), 0};
        foreach (domains[p])
        begin
            set_domain(domains[p]);
            if (p == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (p == 1 && i == PHASE_WORDS / 2)
                begin
                    go_quiet();
                    drain();
                end
                random_word();
            end
        end

        go_quiet();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
